// ===== sv/ppmt_pkg.sv =====
`timescale 1ns / 1ps
package ppmt_pkg;

  localparam int W_PID  = 22;
  localparam int W_ADDR = 48;
  localparam int W_SIZE = 48;
  localparam int W_RC   = 10;
  localparam int W_API  = 3;

  localparam logic [W_SIZE-1:0] SIZE_MAX = {W_SIZE{1'b1}};

  // classification made at the front
  typedef enum logic [1:0] {
    K_ALLOC_OK,
    K_ALLOC_FAIL,
    K_FREE
  } kind_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ESCAN,
    S_PSCAN,
    S_CALC,
    S_WRITE
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic              func;
    logic [W_PID-1:0]  pid;
    logic [W_ADDR-1:0] address;
    logic [W_SIZE-1:0] size;
    logic [W_RC-1:0]   rc;
    logic [W_API-1:0]  api;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic [W_PID-1:0]  pid;
    logic [W_ADDR-1:0] address;
    logic [W_SIZE-1:0] size;
  } entry_t;

  typedef struct packed {
    logic              valid;
    logic [W_PID-1:0]  id;
    logic [W_SIZE-1:0] sum;
    logic [W_SIZE-1:0] peak;
  } proc_t;

  // queue handshake between front and back
  typedef struct packed {
    logic  avail;
    item_t head;
  } qhead_t;

  typedef struct packed {
    logic              event_kind;
    logic [W_API-1:0]  api;
    logic [W_SIZE-1:0] size;
    logic [W_ADDR-1:0] address;
    logic [W_RC-1:0]   error;
    logic [W_PID-1:0]  pid;
    logic [W_SIZE-1:0] sum;
    logic [W_SIZE-1:0] peak;
    logic              full;
  } res_t;

endpackage

// ===== sv/ppmt_front.sv =====
`timescale 1ns / 1ps
module ppmt_front import ppmt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              func,
  input  logic [W_PID-1:0]  pid,
  input  logic [W_ADDR-1:0] address,
  input  logic [W_SIZE-1:0] alloc_size,
  input  logic [W_RC-1:0]   return_code,
  input  logic [W_API-1:0]  api_code,
  input  logic              pop,
  output logic              busy,
  output qhead_t            qh
);

  item_t      q [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  item_t      in_item;
  logic       push;

  // classify the incoming word
  always_comb begin
    in_item.func    = func;
    in_item.pid     = pid;
    in_item.address = address;
    in_item.size    = alloc_size;
    in_item.rc      = return_code;
    in_item.api     = api_code;
    if (func) begin
      in_item.kind = K_FREE;
    end else if (return_code == '0 && address != '0 && alloc_size != '0) begin
      in_item.kind = K_ALLOC_OK;
    end else begin
      in_item.kind = K_ALLOC_FAIL;
    end
  end

  assign busy     = (count == 2'd2);
  assign push     = start && !busy;
  assign qh.avail = (count != 2'd0);
  assign qh.head  = q[rp];

  // two-entry queue
  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== sv/ppmt_back.sv =====
`timescale 1ns / 1ps
module ppmt_back import ppmt_pkg::*; #(
  parameter int ALLOC_ENTRIES = 1024,
  parameter int PROC_ENTRIES  = 64
) (
  input  logic   clk,
  input  logic   rst,
  input  qhead_t qh,
  output logic   pop,
  output logic   done,
  output res_t   res
);

  localparam int EW    = $clog2(ALLOC_ENTRIES);
  localparam int PW    = $clog2(PROC_ENTRIES);
  localparam int CLR_N = (ALLOC_ENTRIES > PROC_ENTRIES) ? ALLOC_ENTRIES : PROC_ENTRIES;
  localparam int CW    = $clog2(CLR_N + 1);

  entry_t emem [ALLOC_ENTRIES];
  proc_t  pmem [PROC_ENTRIES];

  state_t state, state_next;

  item_t           it;
  logic [CW-1:0]   clr;
  logic [EW-1:0]   eaddr, erd_idx, eidx, espare;
  logic            eiss_done, erd_v, efound, espare_v;
  entry_t          erd;
  logic [W_SIZE-1:0] esize;
  logic [PW-1:0]   paddr, prd_idx, pidx, pspare;
  logic            piss_done, prd_v, pfound, pspare_v;
  proc_t           prd;
  logic [W_SIZE-1:0] psum, ppeak, newsum;
  logic            table_full;

  // control decoded from state
  logic ehit, e_stop, phit, p_stop, issue_e, issue_p, clr_last;
  logic ovf, do_alloc, do_free, proc_wr;
  logic [W_SIZE:0] sum_add;
  logic [W_SIZE-1:0] base_peak, peak_new;

  assign clr_last = (clr == CW'(CLR_N - 1));
  assign ehit   = erd_v && erd.valid && erd.pid == it.pid && erd.address == it.address;
  assign e_stop = ehit || (erd_v && erd_idx == EW'(ALLOC_ENTRIES - 1));
  assign phit   = prd_v && prd.valid && prd.id == it.pid;
  assign p_stop = phit || (prd_v && prd_idx == PW'(PROC_ENTRIES - 1));

  assign ovf      = (it.kind == K_ALLOC_OK) && ((!efound && !espare_v) || (!pfound && !pspare_v));
  assign do_alloc = (it.kind == K_ALLOC_OK) && !ovf;
  assign do_free  = (it.kind == K_FREE) && efound;
  assign proc_wr  = do_alloc || (do_free && pfound);
  assign sum_add  = {1'b0, (pfound ? psum : '0)} + {1'b0, it.size};
  assign base_peak = pfound ? ppeak : '0;
  assign peak_new  = do_alloc ? ((base_peak < newsum) ? newsum : base_peak) : ppeak;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (qh.avail) begin
          state_next = (qh.head.kind == K_ALLOC_FAIL) ? S_PSCAN : S_ESCAN;
        end
      end
      S_ESCAN: if (e_stop) state_next = S_PSCAN;
      S_PSCAN: if (p_stop) state_next = S_CALC;
      S_CALC:  state_next = S_WRITE;
      S_WRITE: state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    pop     = 1'b0;
    issue_e = 1'b0;
    issue_p = 1'b0;
    case (state)
      S_IDLE:  pop = qh.avail;
      S_ESCAN: issue_e = !eiss_done && !e_stop;
      S_PSCAN: issue_p = !piss_done && !p_stop;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      done       <= 1'b0;
      table_full <= 1'b0;
      erd_v      <= 1'b0;
      prd_v      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_WRITE);
      if (state == S_CLEAR) begin
        clr <= clr + CW'(1);
      end
      if (state == S_WRITE && ovf) begin
        table_full <= 1'b1;
      end
      erd_v <= issue_e;
      prd_v <= issue_p;
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (pop) begin
      it        <= qh.head;
      eaddr     <= '0;
      eiss_done <= 1'b0;
      efound    <= 1'b0;
      espare_v  <= 1'b0;
      paddr     <= '0;
      piss_done <= 1'b0;
      pfound    <= 1'b0;
      pspare_v  <= 1'b0;
    end
    if (issue_e) begin
      eaddr     <= eaddr + EW'(1);
      eiss_done <= (eaddr == EW'(ALLOC_ENTRIES - 1));
    end
    if (state == S_ESCAN && erd_v) begin
      if (ehit) begin
        efound <= 1'b1;
        eidx   <= erd_idx;
        esize  <= erd.size;
      end else if (!erd.valid && !espare_v) begin
        espare_v <= 1'b1;
        espare   <= erd_idx;
      end
    end
    if (issue_p) begin
      paddr     <= paddr + PW'(1);
      piss_done <= (paddr == PW'(PROC_ENTRIES - 1));
    end
    if (state == S_PSCAN && prd_v) begin
      if (phit) begin
        pfound <= 1'b1;
        pidx   <= prd_idx;
        psum   <= prd.sum;
        ppeak  <= prd.peak;
      end else if (!prd.valid && !pspare_v) begin
        pspare_v <= 1'b1;
        pspare   <= prd_idx;
      end
    end
    // new running sum
    if (state == S_CALC) begin
      if (do_alloc) begin
        newsum <= sum_add[W_SIZE] ? SIZE_MAX : sum_add[W_SIZE-1:0];
      end else if (do_free) begin
        newsum <= (psum >= esize) ? (psum - esize) : '0;
      end else begin
        newsum <= psum;
      end
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (state == S_CLEAR && clr < CW'(ALLOC_ENTRIES)) begin
      emem[clr[EW-1:0]] <= '0;
    end else if (state == S_WRITE && do_alloc) begin
      emem[efound ? eidx : espare] <= '{1'b1, it.pid, it.address, it.size};
    end else if (state == S_WRITE && do_free) begin
      emem[eidx] <= '{1'b0, it.pid, it.address, esize};
    end
    erd     <= emem[eaddr];
    erd_idx <= eaddr;
  end

  // process memory
  always_ff @(posedge clk) begin
    if (state == S_CLEAR && clr < CW'(PROC_ENTRIES)) begin
      pmem[clr[PW-1:0]] <= '0;
    end else if (state == S_WRITE && proc_wr) begin
      pmem[pfound ? pidx : pspare] <= '{1'b1, it.pid, newsum, peak_new};
    end
    prd     <= pmem[paddr];
    prd_idx <= paddr;
  end

  // result word
  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      res.event_kind <= it.func;
      res.api        <= it.api;
      res.pid        <= it.pid;
      res.size       <= (it.kind == K_FREE) ? (efound ? esize : '0) : it.size;
      res.address    <= (it.kind == K_ALLOC_FAIL) ? '0 : it.address;
      res.error      <= (it.kind == K_ALLOC_FAIL) ? it.rc : '0;
      res.sum        <= (pfound || do_alloc) ? newsum : '0;
      res.peak       <= (pfound || do_alloc) ? peak_new : '0;
      res.full       <= table_full || ovf;
    end
  end

`ifndef ASSERT_OFF
  a_done_after_write: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_WRITE) else $error("result without write step");
  a_err_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (done && res.error != '0) |-> res.address == '0) else $error("failed alloc with address");
  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(table_full) |-> table_full) else $error("overflow flag dropped");
  a_peak_ge_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> res.peak >= res.sum) else $error("peak below sum");
`endif

endmodule

// ===== sv/per_process_memory_peak_tracker_unit.sv =====
`timescale 1ns / 1ps
// Per-process memory peak tracker.
// Input channel: drive func, pid, address, alloc_size, return_code, api_code
// with start high; the word is taken at a rising edge where busy is low.
// A two-word queue sits in front of the tracking engine, so busy rises only
// when two words are waiting.
// Result channel: one result word per input, on the result ports for a single
// cycle while done is high. The receiver cannot stall; it must take it then.
// Processing: the engine scans the allocation table one entry per cycle through
// its single read port, then the process table the same way, then runs the
// sum update and write back steps. Each scan stops early when the match is
// found; a failed allocation skips the allocation table scan.
// Reset: synchronous rst empties the queue and clears the flag, then the
// engine clears both tables, one entry per cycle, before it starts on queued
// words.
module per_process_memory_peak_tracker_unit import ppmt_pkg::*; #(
  parameter int ALLOC_ENTRIES = 1024,
  parameter int PROC_ENTRIES  = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              func,
  input  logic [W_PID-1:0]  pid,
  input  logic [W_ADDR-1:0] address,
  input  logic [W_SIZE-1:0] alloc_size,
  input  logic [W_RC-1:0]   return_code,
  input  logic [W_API-1:0]  api_code,
  output logic              done,
  output logic              event_kind,
  output logic [W_API-1:0]  api_out,
  output logic [W_SIZE-1:0] report_size,
  output logic [W_ADDR-1:0] report_address,
  output logic [W_RC-1:0]   error_code,
  output logic [W_PID-1:0]  pid_out,
  output logic [W_SIZE-1:0] proc_sum_out,
  output logic [W_SIZE-1:0] proc_peak_out,
  output logic              table_full
);

  qhead_t qh;
  logic   pop;
  res_t   res;

  ppmt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .func        (func),
    .pid         (pid),
    .address     (address),
    .alloc_size  (alloc_size),
    .return_code (return_code),
    .api_code    (api_code),
    .pop         (pop),
    .busy        (busy),
    .qh          (qh)
  );

  ppmt_back #(
    .ALLOC_ENTRIES (ALLOC_ENTRIES),
    .PROC_ENTRIES  (PROC_ENTRIES)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .qh   (qh),
    .pop  (pop),
    .done (done),
    .res  (res)
  );

  // unpack result word
  assign event_kind     = res.event_kind;
  assign api_out        = res.api;
  assign report_size    = res.size;
  assign report_address = res.address;
  assign error_code     = res.error;
  assign pid_out        = res.pid;
  assign proc_sum_out   = res.sum;
  assign proc_peak_out  = res.peak;
  assign table_full     = res.full;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import ppmt_pkg::*;

  localparam int ALLOC_DEPTH = 1024;
  localparam int PROC_DEPTH  = 64;
  localparam logic [W_SIZE-1:0] TOP = {W_SIZE{1'b1}};
  localparam int WDOG_LIMIT  = 20000;
  localparam int TAIL_CYCLES = 2000;
  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [W_PID-1:0]  pid;
    logic [W_ADDR-1:0] address;
    logic [W_SIZE-1:0] size;
    logic [W_RC-1:0]   rc;
    logic [W_API-1:0]  api;
  } word_t;

  // tracker state mirror and queue of expected reports
  class peak_scoreboard;
    logic [W_SIZE-1:0] entry_size [logic [W_PID+W_ADDR-1:0]];
    logic [W_SIZE-1:0] run_sum [logic [W_PID-1:0]];
    logic [W_SIZE-1:0] run_peak [logic [W_PID-1:0]];
    logic [W_PID+W_ADDR-1:0] live_keys[$];
    logic full_flag;
    res_t pending[$];
    int errors;

    function void note(word_t w);
      res_t r;
      logic [W_PID+W_ADDR-1:0] key;
      logic [W_SIZE:0] acc;
      int k;
      key = {w.pid, w.address};
      r = '0;
      r.event_kind = w.func;
      r.api = w.api;
      r.pid = w.pid;
      r.address = w.address;
      if (w.func == FN_ALLOC) begin
        r.size = w.size;
        if (w.rc == 0 && w.address != 0 && w.size != 0) begin
          if ((!entry_size.exists(key) && entry_size.num() >= ALLOC_DEPTH) ||
              (!run_sum.exists(w.pid) && run_sum.num() >= PROC_DEPTH)) begin
            full_flag = 1'b1;
          end else begin
            if (!entry_size.exists(key)) live_keys.push_back(key);
            entry_size[key] = w.size;
            if (!run_sum.exists(w.pid)) begin
              run_sum[w.pid] = '0;
              run_peak[w.pid] = '0;
            end
            acc = run_sum[w.pid] + w.size;
            run_sum[w.pid] = acc[W_SIZE] ? TOP : acc[W_SIZE-1:0];
            if (run_peak[w.pid] < run_sum[w.pid]) run_peak[w.pid] = run_sum[w.pid];
          end
        end else begin
          r.address = '0;
          r.error = w.rc;
        end
      end else if (entry_size.exists(key)) begin
        r.size = entry_size[key];
        entry_size.delete(key);
        for (k = 0; k < live_keys.size(); k++)
          if (live_keys[k] == key) begin
            live_keys.delete(k);
            break;
          end
        if (run_sum.exists(w.pid))
          run_sum[w.pid] = (run_sum[w.pid] >= r.size) ? run_sum[w.pid] - r.size : '0;
      end
      if (run_sum.exists(w.pid)) begin
        r.sum = run_sum[w.pid];
        r.peak = run_peak[w.pid];
      end
      r.full = full_flag;
      pending.push_back(r);
    endfunction

    function void field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t %s mismatch: expected %h actual %h", $realtime, name, exp_v, act_v);
      end
    endfunction

    function void check(res_t act);
      res_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected report: expected none actual %h", $realtime, act);
        return;
      end
      e = pending.pop_front();
      field("event_kind", e.event_kind, act.event_kind);
      field("api_out", e.api, act.api);
      field("report_size", e.size, act.size);
      field("report_address", e.address, act.address);
      field("error_code", e.error, act.error);
      field("pid_out", e.pid, act.pid);
      field("proc_sum_out", e.sum, act.sum);
      field("proc_peak_out", e.peak, act.peak);
      field("table_full", e.full, act.full);
    endfunction
  endclass

  logic clk, rst, start, busy, done;
  logic func, event_kind, table_full;
  logic [W_PID-1:0] pid, pid_out;
  logic [W_ADDR-1:0] address, report_address;
  logic [W_SIZE-1:0] alloc_size, report_size, proc_sum_out, proc_peak_out;
  logic [W_RC-1:0] return_code, error_code;
  logic [W_API-1:0] api_code, api_out;

  per_process_memory_peak_tracker_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .pid(pid), .address(address), .alloc_size(alloc_size),
    .return_code(return_code), .api_code(api_code),
    .done(done), .event_kind(event_kind), .api_out(api_out),
    .report_size(report_size), .report_address(report_address),
    .error_code(error_code), .pid_out(pid_out), .proc_sum_out(proc_sum_out),
    .proc_peak_out(proc_peak_out), .table_full(table_full)
  );

  peak_scoreboard sb = new();
  int quiet_cycles = 0;
  bit gaps_on;
  logic [W_PID-1:0] pid_pool[32];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // accept monitor, report checker and stall watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note({func, pid, address, alloc_size, return_code, api_code});
      if (done)
        sb.check({event_kind, api_out, report_size, report_address, error_code,
                  pid_out, proc_sum_out, proc_peak_out, table_full});
      if ((start && !busy) || done) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  task automatic send(word_t w);
    bit taken;
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 23) begin
      start = 1'b0;
      @(negedge clk);
    end
    {func, pid, address, alloc_size, return_code, api_code} = w;
    start = 1'b1;
    do begin
      @(posedge clk);
      taken = !busy;
    end while (!taken);
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic logic [W_SIZE-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 4) return TOP;
    if (r < 10) return W_SIZE'({$urandom, $urandom}) | 48'h1;
    return W_SIZE'($urandom_range(1 << 20, 1));
  endfunction

  function automatic logic [W_ADDR-1:0] pick_addr();
    logic [W_ADDR-1:0] a;
    a = W_ADDR'({$urandom, $urandom});
    return (a == 0) ? 48'h1 : a;
  endfunction

  function automatic word_t alloc_word(logic [W_PID-1:0] p, logic [W_ADDR-1:0] a,
                                       logic [W_SIZE-1:0] s);
    return {FN_ALLOC, p, a, s, W_RC'(0), W_API'($urandom)};
  endfunction

  function automatic word_t free_word(logic [W_PID-1:0] p, logic [W_ADDR-1:0] a);
    return {FN_FREE, p, a, W_SIZE'({$urandom, $urandom}), W_RC'($urandom), W_API'($urandom)};
  endfunction

  // mostly well-formed alloc/free traffic over a fixed set of processes
  function automatic word_t random_word();
    int r;
    logic [W_PID+W_ADDR-1:0] key;
    word_t w;
    r = $urandom_range(99);
    if (r < 55 && sb.live_keys.size() > 0) begin
      key = sb.live_keys[$urandom_range(sb.live_keys.size() - 1)];
      if (r < 12) return alloc_word(key[W_PID+W_ADDR-1:W_ADDR], key[W_ADDR-1:0], pick_size());
      return free_word(key[W_PID+W_ADDR-1:W_ADDR], key[W_ADDR-1:0]);
    end
    if (r < 88) return alloc_word(pid_pool[$urandom_range(31)], pick_addr(), pick_size());
    if (r < 93) return free_word(pid_pool[$urandom_range(31)], pick_addr());
    // failed allocation variants
    w = alloc_word(pid_pool[$urandom_range(31)], pick_addr(), pick_size());
    case ($urandom_range(2))
      0: w.rc = W_RC'($urandom_range(1023, 1));
      1: w.address = '0;
      default: w.size = '0;
    endcase
    return w;
  endfunction

  task automatic drain();
    wait (sb.pending.size() == 0);
  endtask

  initial begin
    int n, k;
    logic [W_PID-1:0] fresh;
    rst = 1'b1;
    start = 1'b0;
    {func, pid, address, alloc_size, return_code, api_code} = '0;
    gaps_on = 1'b1;
    sb.full_flag = 1'b0;
    sb.errors = 0;
    pid_pool[0] = '0;
    pid_pool[1] = {W_PID{1'b1}};
    for (k = 2; k < 32; k++) pid_pool[k] = W_PID'($urandom);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, repeats, saturation, unknown frees, failures
    send(alloc_word('0, 48'h1, 48'h1));
    send(alloc_word({W_PID{1'b1}}, TOP, TOP));
    send(alloc_word({W_PID{1'b1}}, TOP, 48'h5));
    send(alloc_word({W_PID{1'b1}}, 48'h10, 48'h100));
    send(free_word({W_PID{1'b1}}, TOP));
    send(free_word({W_PID{1'b1}}, TOP));
    send(free_word({W_PID{1'b1}}, 48'h10));
    send(free_word('0, 48'h2));
    send(free_word(22'h1234, 48'h1));
    send({FN_ALLOC, 22'h2AAAAA, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 10'h3FF, 3'h7});
    send({FN_ALLOC, 22'h155555, 48'h0, 48'h40, 10'h0, 3'h0});
    send({FN_ALLOC, 22'h155555, 48'h80, 48'h0, 10'h0, 3'h5});
    send({FN_ALLOC, 22'h155555, 48'h0, 48'h0, 10'h201, 3'h2});
    send(alloc_word('0, 48'h1, 48'h1000));
    send(alloc_word('0, 48'h2, 48'h30));
    send(free_word('0, 48'h1));
    send(alloc_word('0, 48'h1, 48'h8));
    send(free_word('0, 48'h2));
    send(free_word('0, 48'h1));
    drain();

    // random traffic, with one stretch of words sent without random gaps
    for (n = 0; n < 100; n++) begin
      gaps_on = !(n >= 20 && n < 70);
      send(random_word());
      if (n == 80) drain();
    end
    gaps_on = 1'b1;

    // fill the allocation table until an insert overflows
    while (sb.entry_size.num() < ALLOC_DEPTH) send(alloc_word(pid_pool[2], pick_addr(), 48'h3));
    send(alloc_word(pid_pool[3], pick_addr(), 48'h7));
    for (n = 0; n < 40; n++) send(random_word());

    // fill the process table until an insert overflows
    drain();
    for (k = 0; k < PROC_DEPTH && sb.live_keys.size() > 0; k++)
      send(free_word(sb.live_keys[0][W_PID+W_ADDR-1:W_ADDR], sb.live_keys[0][W_ADDR-1:0]));
    fresh = 22'h3000;
    while (sb.run_sum.num() < PROC_DEPTH && fresh < 22'h3100) begin
      send(alloc_word(fresh, pick_addr(), 48'h9));
      fresh++;
    end
    send(alloc_word(fresh, pick_addr(), 48'h9));

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      if (sb.pending.size() != 0)
        $display("%0t missing reports: expected %0d actual 0", $realtime, sb.pending.size());
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/ppmt_pkg.sv
sv/ppmt_front.sv
sv/ppmt_back.sv
sv/per_process_memory_peak_tracker_unit.sv
bench/tb.sv
